### rtl/core/sfsd_pkg.sv
`timescale 1ns / 1ps

package sfsd_pkg;

  // Pen grid coordinate width
  localparam int PEN_W = 5;

  // Scale register reset value, 1.0 in Q8.8
  localparam logic [15:0] SCALE_RESET = 16'd256;

  // Stroke byte codes
  localparam logic [7:0] CODE_SPACE      = 8'h20;
  localparam logic [7:0] CODE_IGN_QUOTE  = 8'h27;
  localparam logic [7:0] CODE_IGN_BSL    = 8'h5C;
  localparam logic [7:0] CODE_IGN_BRK    = 8'h5D;
  localparam logic [7:0] CODE_XSET_A_LO  = 8'h21;
  localparam logic [7:0] CODE_XSET_A_HI  = 8'h26;
  localparam logic [7:0] CODE_XSET_B_LO  = 8'h28;
  localparam logic [7:0] CODE_XSET_B_HI  = 8'h3F;
  localparam logic [7:0] CODE_XDRAW_A_LO = 8'h40;
  localparam logic [7:0] CODE_XDRAW_A_HI = 8'h5B;
  localparam logic [7:0] CODE_XDRAW_B_LO = 8'h5E;
  localparam logic [7:0] CODE_XDRAW_B_HI = 8'h5F;
  localparam logic [7:0] CODE_XTO_LO     = 8'h60;
  localparam logic [7:0] CODE_XTO_HI     = 8'h7D;
  localparam logic [7:0] CODE_YZERO      = 8'h7E;
  localparam logic [7:0] CODE_YSET_LO    = 8'hA1;
  localparam logic [7:0] CODE_YSET_HI    = 8'hBF;
  localparam logic [7:0] CODE_YDRAW_LO   = 8'hC0;
  localparam logic [7:0] CODE_YDRAW_HI   = 8'hDF;

  // Grid offsets for the ranges that do not start at zero
  localparam logic [7:0] XSET_B_OFS  = 8'd6;
  localparam logic [7:0] XDRAW_B_OFS = 8'd28;
  localparam logic [7:0] YSET_OFS    = 8'd1;

  // Pen points of one segment on the glyph grid
  typedef struct packed {
    logic [PEN_W-1:0] from_x;
    logic [PEN_W-1:0] from_y;
    logic [PEN_W-1:0] to_x;
    logic [PEN_W-1:0] to_y;
  } sfsd_seg_t;

endpackage

### rtl/core/stroke_font_segment_decoder.sv
`timescale 1ns / 1ps

// Stroke font segment decoder.
//
// Input channel (in_valid / in_stall): one stroke-code byte per word, with a
// glyph start flag and the screen origin of the glyph. Every accepted word
// updates the pen at once; only drawing codes produce an output word.
// Output channel (out_valid / out_stall): one line segment per drawing code,
// both end points in screen coordinates, scaled by cfg scale and saturated.
// Configuration: cfg_wr_en writes cfg_wr_data into the Q8.8 scale register;
// write it only while no segment is in flight.
// Timing: the pen is decoded in the cycle that accepts a byte and the segment
// is held in the decode stage register; the four scale multiplies and
// saturation lie between that register and the output register.
// Throughput: one byte per cycle while in_stall is low, set by the pen update loop.
// The receiver may stall: the two-stage pipeline holds its words, and
// in_stall rises only when both stages are full and out_stall is high.
// Reset clears the pen, the byte count, the glyph-ended flag and both
// pipeline stages, and sets the scale to 1.0.

module stroke_font_segment_decoder #(
  parameter int GLYPH_HEIGHT     = 32,
  parameter int MAX_STROKE_BYTES = 155
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_stroke_byte,
  input  logic               in_glyph_start,
  input  logic signed [15:0] in_origin_x,
  input  logic signed [15:0] in_origin_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_seg_x0,
  output logic signed [15:0] out_seg_y0,
  output logic signed [15:0] out_seg_x1,
  output logic signed [15:0] out_seg_y1
);
  import sfsd_pkg::*;

  // Signed width that holds both the flipped Y and a plain grid X
  localparam int CW = $clog2(GLYPH_HEIGHT + 1) + 1;
  localparam logic signed [CW-1:0] GH_S = CW'(GLYPH_HEIGHT);

  logic [15:0] scale_r;

  logic        in_accept;
  logic        adv_w;
  logic        draw_w;
  sfsd_seg_t   seg_w;

  logic               s1_valid_r;
  sfsd_seg_t          s1_seg_r;
  logic signed [15:0] s1_ox_r, s1_oy_r;

  logic signed [CW-1:0] cx0_w, cy0_w, cx1_w, cy1_w;
  logic signed [15:0]   px0_w, py0_w, px1_w, py1_w;

  logic               out_valid_r;
  logic signed [15:0] x0_r, y0_r, x1_r, y1_r;

  // Pipeline moves when the output register is empty or being taken.
  assign adv_w     = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !adv_w;
  assign in_accept = in_valid && !in_stall;

  // Scale register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
    end else if (cfg_wr_en) begin
      scale_r <= cfg_wr_data;
    end
  end

  sfsd_pen_decode #(
    .MAX_STROKE_BYTES(MAX_STROKE_BYTES)
  ) u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_accept),
    .stroke_byte(in_stroke_byte),
    .glyph_start(in_glyph_start),
    .draw       (draw_w),
    .seg        (seg_w)
  );

  // Decode stage register: one pending segment on the grid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= draw_w;
    end else if (adv_w) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_seg_r <= seg_w;
      s1_ox_r  <= in_origin_x;
      s1_oy_r  <= in_origin_y;
    end
  end

  // Grid coordinates, Y flipped against the glyph height
  assign cx0_w = CW'(s1_seg_r.from_x);
  assign cx1_w = CW'(s1_seg_r.to_x);
  assign cy0_w = GH_S - CW'(s1_seg_r.from_y);
  assign cy1_w = GH_S - CW'(s1_seg_r.to_y);

  sfsd_place #(.CW(CW)) u_place_x0 (
    .coord(cx0_w), .scale(scale_r), .org(s1_ox_r), .pos(px0_w)
  );
  sfsd_place #(.CW(CW)) u_place_y0 (
    .coord(cy0_w), .scale(scale_r), .org(s1_oy_r), .pos(py0_w)
  );
  sfsd_place #(.CW(CW)) u_place_x1 (
    .coord(cx1_w), .scale(scale_r), .org(s1_ox_r), .pos(px1_w)
  );
  sfsd_place #(.CW(CW)) u_place_y1 (
    .coord(cy1_w), .scale(scale_r), .org(s1_oy_r), .pos(py1_w)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_w) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_w && s1_valid_r) begin
      x0_r <= px0_w;
      y0_r <= py0_w;
      x1_r <= px1_w;
      y1_r <= py1_w;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_seg_x0 = x0_r;
  assign out_seg_y0 = y0_r;
  assign out_seg_x1 = x1_r;
  assign out_seg_y1 = y1_r;

endmodule

### rtl/core/sfsd_pen_decode.sv
`timescale 1ns / 1ps

module sfsd_pen_decode #(
  parameter int MAX_STROKE_BYTES = 155
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          stroke_byte,
  input  logic                glyph_start,
  output logic                draw,
  output sfsd_pkg::sfsd_seg_t seg
);
  import sfsd_pkg::*;

  logic [PEN_W-1:0] from_x_r, from_y_r, to_x_r, to_y_r;
  logic [PEN_W-1:0] from_x_nxt, from_y_nxt, to_x_nxt, to_y_nxt;
  logic             done_r, done_nxt;
  logic [7:0]       cnt_r, cnt_nxt;

  // Pen state as seen by this byte, after an optional glyph clear
  logic [PEN_W-1:0] fx_c, fy_c, tx_c, ty_c;
  logic             done_c;
  logic [7:0]       cnt_c;

  assign fx_c   = glyph_start ? '0 : from_x_r;
  assign fy_c   = glyph_start ? '0 : from_y_r;
  assign tx_c   = glyph_start ? '0 : to_x_r;
  assign ty_c   = glyph_start ? '0 : to_y_r;
  assign done_c = glyph_start ? 1'b0 : done_r;
  assign cnt_c  = glyph_start ? '0 : cnt_r;

  // Decode one byte and work out the next pen state
  always_comb begin
    from_x_nxt = from_x_r;
    from_y_nxt = from_y_r;
    to_x_nxt   = to_x_r;
    to_y_nxt   = to_y_r;
    done_nxt   = done_r;
    cnt_nxt    = cnt_r;
    draw       = 1'b0;
    if (accept) begin
      from_x_nxt = fx_c;
      from_y_nxt = fy_c;
      to_x_nxt   = tx_c;
      to_y_nxt   = ty_c;
      done_nxt   = done_c;
      cnt_nxt    = cnt_c;
      if (!done_c && (cnt_c < 8'(MAX_STROKE_BYTES))) begin
        cnt_nxt = cnt_c + 8'd1;
        if (stroke_byte == CODE_SPACE) begin
          done_nxt = 1'b1;
        end else if (stroke_byte == CODE_IGN_QUOTE || stroke_byte == CODE_IGN_BSL ||
                     stroke_byte == CODE_IGN_BRK) begin
          // Ignored codes only count as a byte.
        end else if (stroke_byte inside {[CODE_XSET_A_LO:CODE_XSET_A_HI]}) begin
          from_x_nxt = PEN_W'(stroke_byte - CODE_XSET_A_LO);
          to_x_nxt   = PEN_W'(stroke_byte - CODE_XSET_A_LO);
        end else if (stroke_byte inside {[CODE_XSET_B_LO:CODE_XSET_B_HI]}) begin
          from_x_nxt = PEN_W'(stroke_byte - CODE_XSET_B_LO + XSET_B_OFS);
          to_x_nxt   = PEN_W'(stroke_byte - CODE_XSET_B_LO + XSET_B_OFS);
        end else if (stroke_byte inside {[CODE_XDRAW_A_LO:CODE_XDRAW_A_HI]}) begin
          to_x_nxt   = PEN_W'(stroke_byte - CODE_XDRAW_A_LO);
          from_x_nxt = to_x_nxt;
          draw       = 1'b1;
        end else if (stroke_byte inside {[CODE_XDRAW_B_LO:CODE_XDRAW_B_HI]}) begin
          to_x_nxt   = PEN_W'(stroke_byte - CODE_XDRAW_B_LO + XDRAW_B_OFS);
          from_x_nxt = to_x_nxt;
          draw       = 1'b1;
        end else if (stroke_byte inside {[CODE_XTO_LO:CODE_XTO_HI]}) begin
          to_x_nxt = PEN_W'(stroke_byte - CODE_XTO_LO);
        end else if (stroke_byte == CODE_YZERO) begin
          from_y_nxt = '0;
          to_y_nxt   = '0;
        end else if (stroke_byte inside {[CODE_YSET_LO:CODE_YSET_HI]}) begin
          from_y_nxt = PEN_W'(stroke_byte - CODE_YSET_LO + YSET_OFS);
          to_y_nxt   = PEN_W'(stroke_byte - CODE_YSET_LO + YSET_OFS);
        end else if (stroke_byte inside {[CODE_YDRAW_LO:CODE_YDRAW_HI]}) begin
          to_y_nxt   = PEN_W'(stroke_byte - CODE_YDRAW_LO);
          from_x_nxt = tx_c;
          from_y_nxt = to_y_nxt;
          draw       = 1'b1;
        end
      end
    end
  end

  // The segment runs from the old start point to the new end point.
  assign seg.from_x = fx_c;
  assign seg.from_y = fy_c;
  assign seg.to_x   = to_x_nxt;
  assign seg.to_y   = to_y_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      from_x_r <= '0;
      from_y_r <= '0;
      to_x_r   <= '0;
      to_y_r   <= '0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      from_x_r <= from_x_nxt;
      from_y_r <= from_y_nxt;
      to_x_r   <= to_x_nxt;
      to_y_r   <= to_y_nxt;
      done_r   <= done_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

### rtl/core/sfsd_place.sv
`timescale 1ns / 1ps

module sfsd_place #(
  parameter int CW = 8
) (
  input  logic signed [CW-1:0] coord,
  input  logic        [15:0]   scale,
  input  logic signed [15:0]   org,
  output logic signed [15:0]   pos
);
  import sfsd_pkg::*;

  localparam int NW = CW + 19;
  localparam int QW = NW - 8;
  localparam logic signed [QW-1:0] QMAX = QW'(32767);
  localparam logic signed [QW-1:0] QMIN = QW'(-32768);

  logic signed [NW-1:0] prod_w, org_w, num_w;
  logic signed [QW-1:0] quot_w, adj_w;
  logic                 fix_w;

  // Exact sum of origin and scaled grid coordinate, in units of 1/256
  assign prod_w = NW'(coord) * NW'(signed'({1'b0, scale}));
  assign org_w  = NW'(org) <<< 8;
  assign num_w  = prod_w + org_w;

  // Divide by 256 with truncation toward zero
  assign quot_w = num_w[NW-1:8];
  assign fix_w  = num_w[NW-1] && (num_w[7:0] != 8'd0);
  assign adj_w  = quot_w + QW'(fix_w);

  // Saturate to the signed 16-bit screen range
  always_comb begin
    if (adj_w > QMAX) begin
      pos = 16'sh7FFF;
    end else if (adj_w < QMIN) begin
      pos = -16'sh8000;
    end else begin
      pos = adj_w[15:0];
    end
  end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import sfsd_pkg::*;

  localparam int GLYPH_H = 32;
  localparam int BYTE_LIMIT = 155;
  localparam int LATENCY = 2;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASES = 6;
  localparam int WORDS_PER_PHASE = 105;

  // One line segment in screen coordinates, as the block presents it.
  typedef struct packed {
    logic [15:0] x0;
    logic [15:0] y0;
    logic [15:0] x1;
    logic [15:0] y1;
  } segment_t;

  // Pen decoder model plus the queue of segments still owed by the block.
  class segment_scoreboard;
    logic [15:0] scale;
    logic [PEN_W-1:0] from_x, from_y, to_x, to_y;
    bit glyph_ended;
    int unsigned byte_count;
    segment_t owed[$];
    int errors;

    function new();
      clear_pen();
      scale = SCALE_RESET;
      errors = 0;
    endfunction

    function void clear_pen();
      from_x = '0;
      from_y = '0;
      to_x = '0;
      to_y = '0;
      glyph_ended = 1'b0;
      byte_count = 0;
    endfunction

    // Screen coordinate: origin plus grid point times scale, truncated and saturated.
    function logic [15:0] place(logic signed [15:0] org, int coord);
      longint num;
      longint v;
      num = longint'(org) * 256 + longint'(coord) * longint'(scale);
      v = num / 256;
      if (v > 32767) begin
        v = 32767;
      end else if (v < -32768) begin
        v = -32768;
      end
      return v[15:0];
    endfunction

    function void owe_segment(logic signed [15:0] ox, logic signed [15:0] oy);
      segment_t s;
      s.x0 = place(ox, int'(from_x));
      s.y0 = place(oy, GLYPH_H - int'(from_y));
      s.x1 = place(ox, int'(to_x));
      s.y1 = place(oy, GLYPH_H - int'(to_y));
      owed.push_back(s);
    endfunction

    // Applies one accepted word to the pen; returns 1 when the word counted.
    function bit note_word(logic [7:0] code, bit start, logic signed [15:0] ox,
                           logic signed [15:0] oy);
      if (start) clear_pen();
      if (glyph_ended || byte_count >= BYTE_LIMIT) return 1'b0;
      byte_count++;
      // Bytes between the listed ranges (quote, backslash, bracket and the rest) fall through.
      if (code == CODE_SPACE) begin
        glyph_ended = 1'b1;
      end else if (code >= CODE_XSET_A_LO && code <= CODE_XSET_A_HI) begin
        from_x = PEN_W'(code - CODE_XSET_A_LO);
        to_x = from_x;
      end else if (code >= CODE_XSET_B_LO && code <= CODE_XSET_B_HI) begin
        from_x = PEN_W'(code - CODE_XSET_B_LO + XSET_B_OFS);
        to_x = from_x;
      end else if (code >= CODE_XDRAW_A_LO && code <= CODE_XDRAW_A_HI) begin
        to_x = PEN_W'(code - CODE_XDRAW_A_LO);
        owe_segment(ox, oy);
        from_x = to_x;
      end else if (code >= CODE_XDRAW_B_LO && code <= CODE_XDRAW_B_HI) begin
        to_x = PEN_W'(code - CODE_XDRAW_B_LO + XDRAW_B_OFS);
        owe_segment(ox, oy);
        from_x = to_x;
      end else if (code >= CODE_XTO_LO && code <= CODE_XTO_HI) begin
        to_x = PEN_W'(code - CODE_XTO_LO);
      end else if (code == CODE_YZERO) begin
        from_y = '0;
        to_y = '0;
      end else if (code >= CODE_YSET_LO && code <= CODE_YSET_HI) begin
        from_y = PEN_W'(code - CODE_YSET_LO + YSET_OFS);
        to_y = from_y;
      end else if (code >= CODE_YDRAW_LO && code <= CODE_YDRAW_HI) begin
        to_y = PEN_W'(code - CODE_YDRAW_LO);
        owe_segment(ox, oy);
        from_x = to_x;
        from_y = to_y;
      end
      return 1'b1;
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) begin
        report($sformatf("%s is %0d, expected %0d", name, $signed(got), $signed(want)));
      end
    endtask

    task check_segment(segment_t got);
      segment_t want;
      if (owed.size() == 0) begin
        report($sformatf("segment (%0d,%0d)-(%0d,%0d) arrived with none expected",
                         $signed(got.x0), $signed(got.y0), $signed(got.x1), $signed(got.y1)));
        return;
      end
      want = owed.pop_front();
      compare_field("seg_x0", got.x0, want.x0);
      compare_field("seg_y0", got.y0, want.y0);
      compare_field("seg_x1", got.x1, want.x1);
      compare_field("seg_y1", got.y1, want.y1);
    endtask

    task check_drained();
      if (owed.size() != 0) begin
        report($sformatf("%0d segments never arrived", owed.size()));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic in_valid;
  logic in_stall;
  logic [7:0] in_stroke_byte;
  logic in_glyph_start;
  logic signed [15:0] in_origin_x;
  logic signed [15:0] in_origin_y;
  logic out_valid;
  logic out_stall;
  logic signed [15:0] out_seg_x0;
  logic signed [15:0] out_seg_y0;
  logic signed [15:0] out_seg_x1;
  logic signed [15:0] out_seg_y1;

  int send_idle_pct;
  int recv_stall_pct;
  logic hold_active;
  event hold_off_ev;

  segment_scoreboard sb = new();

  stroke_font_segment_decoder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_stroke_byte (in_stroke_byte),
    .in_glyph_start (in_glyph_start),
    .in_origin_x    (in_origin_x),
    .in_origin_y    (in_origin_y),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_seg_x0     (out_seg_x0),
    .out_seg_y0     (out_seg_y0),
    .out_seg_x1     (out_seg_x1),
    .out_seg_y1     (out_seg_y1)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A long receiver hold-off, counted here so the sender keeps pushing meanwhile.
  initial begin
    hold_active = 1'b0;
    forever begin
      @(hold_off_ev);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clk);
      hold_active <= 1'b0;
    end
  end

  // Receiver stalls at random, or solidly during a hold-off.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= hold_active || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Every segment word taken by the receiver is checked against the oldest one owed.
  always @(posedge clk) begin
    segment_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.x0 = out_seg_x0;
      got.y0 = out_seg_y0;
      got.x1 = out_seg_x1;
      got.y1 = out_seg_y1;
      sb.check_segment(got);
    end
  end

  // Ends the run if neither channel moves a word for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [15:0] pick_origin();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      4, 5, 6: return 16'($urandom_range(400) - 200);
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly meaningful stroke codes, with six in a hundred arbitrary bytes as noise.
  function automatic logic [7:0] pick_code();
    int r;
    r = $urandom_range(99);
    if (r < 14) begin
      if ($urandom_range(3) == 0) return 8'($urandom_range(CODE_XSET_A_HI, CODE_XSET_A_LO));
      return 8'($urandom_range(CODE_XSET_B_HI, CODE_XSET_B_LO));
    end else if (r < 28) begin
      if ($urandom_range(5) == 0) return CODE_YZERO;
      return 8'($urandom_range(CODE_YSET_HI, CODE_YSET_LO));
    end else if (r < 40) begin
      return 8'($urandom_range(CODE_XTO_HI, CODE_XTO_LO));
    end else if (r < 66) begin
      if ($urandom_range(9) == 0) return 8'($urandom_range(CODE_XDRAW_B_HI, CODE_XDRAW_B_LO));
      return 8'($urandom_range(CODE_XDRAW_A_HI, CODE_XDRAW_A_LO));
    end else if (r < 90) begin
      return 8'($urandom_range(CODE_YDRAW_HI, CODE_YDRAW_LO));
    end else if (r < 94) begin
      case ($urandom_range(2))
        0: return CODE_IGN_QUOTE;
        1: return CODE_IGN_BSL;
        default: return CODE_IGN_BRK;
      endcase
    end
    return 8'($urandom_range(255));
  endfunction

  // Offers one word, with random idle cycles first, and waits until it is taken.
  task send_word(input logic [7:0] code, input bit start, input logic [15:0] ox,
                 input logic [15:0] oy, output bit counted);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_stroke_byte <= code;
    in_glyph_start <= start;
    in_origin_x <= ox;
    in_origin_y <= oy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    counted = sb.note_word(code, start, ox, oy);
    @(negedge clk);
  endtask

  // Waits until every owed segment has come out and the pipeline has emptied.
  task wait_drained();
    while (sb.owed.size() != 0) @(negedge clk);
    repeat (LATENCY + 3) @(negedge clk);
  endtask

  task write_scale(logic [15:0] value);
    in_valid <= 1'b0;
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.scale = value;
  endtask

  // Every code range at both ends, the ignored bytes, a word before any glyph
  // start, a word after the glyph has ended, and origins at the corners.
  task run_directed();
    logic [7:0] codes [25];
    logic [15:0] corner [5];
    bit counted;
    int i;
    codes = '{CODE_XDRAW_A_LO, CODE_XSET_A_LO, CODE_YSET_LO, CODE_XDRAW_A_HI, CODE_YDRAW_HI,
              CODE_XSET_A_HI, CODE_XSET_B_LO, CODE_XSET_B_HI, CODE_XDRAW_B_LO,
              CODE_XDRAW_B_HI, CODE_XTO_LO, CODE_XTO_HI, CODE_YSET_HI, CODE_YDRAW_LO,
              CODE_YZERO, CODE_IGN_QUOTE, CODE_IGN_BSL, CODE_IGN_BRK, 8'h00, 8'hFF, 8'h80,
              CODE_SPACE, CODE_XDRAW_A_LO, CODE_XDRAW_A_LO, CODE_YDRAW_HI};
    corner = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h04D2};
    for (i = 0; i < 25; i++) begin
      send_word(codes[i], i == 1 || i == 23, corner[i % 5], corner[(i + 2) % 5], counted);
    end
  endtask

  // Glyphs of random content: mostly short, some past the byte limit, most closed
  // by a space and followed by stray bytes that the block must ignore.
  task run_random(int target, bit long_first);
    int live;
    int glyph_len;
    int k;
    int strays;
    bit first;
    bit counted;
    logic [15:0] ox, oy;
    live = 0;
    first = 1'b1;
    while (live < target) begin
      ox = pick_origin();
      oy = pick_origin();
      if ((first && long_first) || $urandom_range(19) == 0) begin
        glyph_len = $urandom_range(200, 160);
      end else begin
        glyph_len = $urandom_range(40, 2);
      end
      first = 1'b0;
      for (k = 0; k < glyph_len; k++) begin
        if ($urandom_range(49) == 0) ox = pick_origin();
        if ($urandom_range(49) == 0) oy = pick_origin();
        send_word(pick_code(), k == 0 && $urandom_range(9) != 0, ox, oy, counted);
        if (counted) live++;
      end
      if ($urandom_range(9) != 0) begin
        send_word(CODE_SPACE, 1'b0, ox, oy, counted);
        if (counted) live++;
        strays = $urandom_range(3);
        for (k = 0; k < strays; k++) begin
          send_word(pick_code(), 1'b0, ox, oy, counted);
        end
      end
    end
  endtask

  initial begin
    int phase;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_stroke_byte = '0;
    in_glyph_start = 1'b0;
    in_origin_x = '0;
    in_origin_y = '0;
    send_idle_pct = 26;
    recv_stall_pct = 76;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_directed();

    // Scale settings: smallest nonzero, largest, zero, then random and nominal ones.
    for (phase = 0; phase < PHASES; phase++) begin
      if (phase == 2) begin
        send_idle_pct = 76;
        recv_stall_pct = 26;
      end else if (phase == 4) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      case (phase)
        0: write_scale(16'd1);
        1: write_scale(16'hFFFF);
        2: write_scale(16'd0);
        3: write_scale(16'($urandom_range(65535, 1)));
        4: write_scale(SCALE_RESET);
        default: write_scale(16'($urandom_range(1024, 64)));
      endcase
      if (phase == 4) -> hold_off_ev;
      run_random(WORDS_PER_PHASE, phase == 1 || phase == 4);
    end

    in_valid <= 1'b0;
    wait_drained();
    sb.check_drained();
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/sfsd_pkg.sv
rtl/core/sfsd_pen_decode.sv
rtl/core/sfsd_place.sv
rtl/core/stroke_font_segment_decoder.sv
tb/sv/testbench.sv
